@@ hw/rtl/skv_pkg.sv @@
// Package for the sorted key/value map: request and status codes, sequencer
// states, compare flags and default sizes. No dependencies.
package skv_pkg;

    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_LOOKUP       = 3'd0,
        REQ_ENTER        = 3'd1,
        REQ_REMOVE_VALUE = 3'd2,
        REQ_REMOVE_KEY   = 3'd3,
        REQ_CLEAR        = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic key_eq;
        logic key_gt;
        logic value_eq;
    } cmp_flags_t;

endpackage

@@ hw/rtl/skv_if.sv @@
// Valid/ready channel interfaces for map requests and map responses.
// Depends on skv_pkg for the code widths.
interface skv_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    import skv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_BITS-1:0]   req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface skv_rsp_if #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 6
);
    import skv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [VALUE_BITS-1:0]  value_out;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, found, value_out, status, entry_count, input ready);
    modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface

@@ hw/rtl/skv_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module skv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/skv_cmp.sv @@
// Shared compare unit: checks one stored entry against the request key and value.
// Depends on skv_pkg for the flag struct.
module skv_cmp #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic [KEY_BITS-1:0]   entry_key,
    input  logic [VALUE_BITS-1:0] entry_value,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    output skv_pkg::cmp_flags_t   flags
);
    import skv_pkg::*;

    always_comb
    begin
        flags.key_eq   = (entry_key == req_key);
        flags.key_gt   = (entry_key > req_key);
        flags.value_eq = (entry_value == req_value);
    end
endmodule

@@ hw/rtl/skv_seq.sv @@
// Sequencer of the sorted map: scans the entry RAM one entry per cycle through the
// shared compare unit, then, to insert or remove, shifts entries up or down. Depends on skv_pkg, skv_if, skv_cmp.
module skv_seq #(
    parameter int CAPACITY   = skv_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = skv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = skv_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    skv_req_if.sink                             req,
    skv_rsp_if.source                           rsp,
    output logic                                ram_we,
    output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
    output logic [KEY_BITS+VALUE_BITS-1:0]      ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
    input  logic [KEY_BITS+VALUE_BITS-1:0]      ram_rdata
);
    import skv_pkg::*;

    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    state_t                 state_reg, state_next;
    req_type_t              op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  idx_reg, idx_next;
    logic [COUNT_BITS-1:0]  pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  left_reg, left_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   up_reg, up_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [ADDR_BITS-1:0]   wr_addr_reg, wr_addr_next;
    logic                   res_found_reg, res_found_next;
    logic [VALUE_BITS-1:0]  res_value_reg, res_value_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;
    logic [COUNT_BITS-1:0]  out_count_reg, out_count_next;

    logic [KEY_BITS-1:0]    entry_key;
    logic [VALUE_BITS-1:0]  entry_value;
    cmp_flags_t             flags;
    logic                   issue;
    logic                   do_insert;
    logic                   do_remove;
    logic                   miss;
    logic [COUNT_BITS-1:0]  start_pos;
    logic [COUNT_BITS-1:0]  idx_step;

    assign entry_key   = ram_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign entry_value = ram_rdata[VALUE_BITS-1:0];

    skv_cmp #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .req_key     (key_reg),
        .req_value   (val_reg),
        .flags       (flags)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.value_out   = out_value_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        cmp_valid_next  = cmp_valid_reg;
        up_next         = up_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[ADDR_BITS-1:0];

        issue     = (idx_reg < count_reg);
        do_insert = 1'b0;
        do_remove = 1'b0;
        miss      = 1'b0;
        start_pos = pos_reg;
        idx_step  = up_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req_type_t'(req.req_type);
                    key_next        = req.key;
                    val_next        = req.value;
                    idx_next        = '0;
                    cmp_valid_next  = 1'b0;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    unique case (req_type_t'(req.req_type))
                        REQ_LOOKUP, REQ_ENTER, REQ_REMOVE_VALUE, REQ_REMOVE_KEY:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // The RAM output holds the entry at pos_reg, read in the previous cycle.
                if (issue)
                begin
                    idx_next       = idx_reg + 1'b1;
                    pos_next       = idx_reg;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end

                if (cmp_valid_reg)
                begin
                    unique case (op_reg)
                        REQ_LOOKUP:
                        begin
                            if (flags.key_eq)
                            begin
                                res_found_next = 1'b1;
                                res_value_next = entry_value;
                                state_next     = ST_DONE;
                            end
                            else if (flags.key_gt)
                            begin
                                miss = 1'b1;
                            end
                        end
                        REQ_ENTER:
                        begin
                            if (flags.key_eq)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = pos_reg[ADDR_BITS-1:0];
                                ram_wdata  = {key_reg, val_reg};
                                state_next = ST_DONE;
                            end
                            else if (flags.key_gt)
                            begin
                                do_insert = 1'b1;
                            end
                        end
                        REQ_REMOVE_VALUE:
                        begin
                            do_remove = flags.value_eq;
                        end
                        REQ_REMOVE_KEY:
                        begin
                            if (flags.key_eq)
                            begin
                                do_remove = 1'b1;
                            end
                            else if (flags.key_gt)
                            begin
                                miss = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (!issue)
                begin
                    // Every stored entry was passed without a decision.
                    if (op_reg == REQ_ENTER)
                    begin
                        do_insert = 1'b1;
                        start_pos = count_reg;
                    end
                    else
                    begin
                        miss = 1'b1;
                    end
                end

                if (miss)
                begin
                    res_status_next = STATUS_NOT_FOUND;
                    state_next      = ST_DONE;
                end

                if (do_insert)
                begin
                    if (count_reg >= COUNT_BITS'(CAPACITY))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        up_next      = 1'b1;
                        pos_next     = start_pos;
                        left_next    = count_reg - start_pos;
                        idx_next     = count_reg - 1'b1;
                        wr_pend_next = 1'b0;
                        state_next   = ST_SHIFT;
                    end
                end

                if (do_remove)
                begin
                    res_found_next = 1'b1;
                    up_next        = 1'b0;
                    pos_next       = pos_reg;
                    left_next      = count_reg - pos_reg - 1'b1;
                    idx_next       = pos_reg + 1'b1;
                    wr_pend_next   = 1'b0;
                    state_next     = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // Read one entry per cycle and write it back one place over on the next.
                if (wr_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end

                if (left_reg != '0)
                begin
                    idx_next     = idx_step;
                    left_next    = left_reg - 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = up_reg ? ADDR_BITS'(idx_reg + 1'b1)
                                          : ADDR_BITS'(idx_reg - 1'b1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        if (up_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pos_reg[ADDR_BITS-1:0];
                            ram_wdata  = {key_reg, val_reg};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        left_reg       <= left_next;
        up_reg         <= up_next;
        wr_addr_reg    <= wr_addr_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end
endmodule

@@ hw/rtl/sorted_array_key_value_map.sv @@
// Sorted key/value map, top level. A clear or an unused code goes from idle straight to the
// done state, whose output registers carry the answer; other requests first scan the stored
// entries through the RAM ports and, to insert or remove, shift them one place over.
// One request is in work at a time: the next is taken once the result is registered,
// and later while a response waits for ready. Reset clears the entry count and the handshake
// state; the RAM contents are not cleared. Depends on skv_pkg, skv_if, skv_ram and skv_seq.
module sorted_array_key_value_map #(
    parameter int CAPACITY   = skv_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = skv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = skv_pkg::DEF_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    skv_req_if.sink   req,
    skv_rsp_if.source rsp
);
    import skv_pkg::*;

    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    skv_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skv_seq #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );
endmodule

@@ bench/tb_sorted_array_key_value_map.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sorted key/value map: it drives random and directed requests,
// keeps a shadow copy of the table, and checks every response in order.
// Depends on skv_pkg, skv_if and the sorted_array_key_value_map RTL.
module tb_sorted_array_key_value_map;
    import skv_pkg::*;

    localparam int CAP   = DEF_CAPACITY;
    localparam int KEY_W = DEF_KEY_BITS;
    localparam int VAL_W = DEF_VALUE_BITS;
    localparam int CNT_W = $clog2(CAP + 1);

    localparam int RANDOM_ITEMS = 1600;
    localparam int KEY_POOL     = 40;
    localparam int VALUE_POOL   = 10;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 2 * CAP + 10;
    localparam int MAX_REPORTS  = 50;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED_FIRST = 3'd5;

    localparam int SEQ_FILL  = 0;
    localparam int SEQ_MIXED = 1;
    localparam int SEQ_DRAIN = 2;

    typedef struct {
        logic [REQ_BITS-1:0] op;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        bit                  drain_first;
        bit                  burst;
    } map_request_t;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] value_out;
        status_t          status;
        logic [CNT_W-1:0] entry_count;
    } map_answer_t;

    logic clk;
    logic rst_n;

    skv_req_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) req_ch ();
    skv_rsp_if #(.VALUE_BITS(VAL_W), .COUNT_BITS(CNT_W)) rsp_ch ();

    sorted_array_key_value_map #(
        .CAPACITY   (CAP),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    map_request_t     queued_requests[$];
    map_answer_t      awaited_answers[$];
    logic [KEY_W-1:0] key_pool[KEY_POOL];
    logic [VAL_W-1:0] value_pool[VALUE_POOL];

    logic [KEY_W-1:0] shadow_keys[CAP];
    logic [VAL_W-1:0] shadow_values[CAP];
    int               shadow_count = 0;

    int  total_requests = 0;
    int  accepted_reqs  = 0;
    int  rsp_count      = 0;
    int  error_count    = 0;
    int  idle_cycles    = 0;
    bit  req_taken      = 1'b0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  calm_left      = 0;
    int  hold_left      = 0;
    int  next_hold_at   = 150;
    int  op_seen[8];
    int  full_seen      = 0;
    int  hit_seen       = 0;
    int  max_fill_seen  = 0;

    map_request_t seen_req;
    map_answer_t  next_answer;
    map_request_t next_req;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return KEY_W'($urandom());
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 80)
            return value_pool[$urandom_range(0, VALUE_POOL - 1)];
        return VAL_W'($urandom());
    endfunction

    // Position of the first stored key that is not below k, or the count on a miss.
    function automatic int first_not_below(input logic [KEY_W-1:0] k);
        int pos;
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_keys[i] >= k)
                pos = i;
        return pos;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_keys[i]   = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
        end
        shadow_count--;
    endfunction

    function automatic map_answer_t apply_map_request(input map_request_t r);
        map_answer_t ans;
        int          pos;
        ans.found     = 1'b0;
        ans.value_out = '0;
        ans.status    = STATUS_OK;
        case (r.op)
            REQ_LOOKUP:
            begin
                pos = first_not_below(r.key);
                if (pos < shadow_count && shadow_keys[pos] == r.key)
                begin
                    ans.found     = 1'b1;
                    ans.value_out = shadow_values[pos];
                end
                else
                    ans.status = STATUS_NOT_FOUND;
            end
            REQ_ENTER:
            begin
                pos = first_not_below(r.key);
                if (pos < shadow_count && shadow_keys[pos] == r.key)
                    shadow_values[pos] = r.value;
                else if (shadow_count >= CAP)
                    ans.status = STATUS_FULL;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i]   = shadow_keys[i - 1];
                        shadow_values[i] = shadow_values[i - 1];
                    end
                    shadow_keys[pos]   = r.key;
                    shadow_values[pos] = r.value;
                    shadow_count++;
                end
            end
            REQ_REMOVE_VALUE:
            begin
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_values[i] == r.value)
                        pos = i;
                if (pos < shadow_count)
                begin
                    drop_entry(pos);
                    ans.found = 1'b1;
                end
                else
                    ans.status = STATUS_NOT_FOUND;
            end
            REQ_REMOVE_KEY:
            begin
                pos = first_not_below(r.key);
                if (pos < shadow_count && shadow_keys[pos] == r.key)
                begin
                    drop_entry(pos);
                    ans.found = 1'b1;
                end
                else
                    ans.status = STATUS_NOT_FOUND;
            end
            REQ_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        ans.entry_count = CNT_W'(shadow_count);
        return ans;
    endfunction

    task automatic add_request(input logic [REQ_BITS-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value, input bit drain_first,
                               input bit burst);
        map_request_t item;
        item.op          = op;
        item.key         = key;
        item.value       = value;
        item.drain_first = drain_first;
        item.burst       = burst;
        queued_requests.push_back(item);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns, response %0d: %s got %h expected %h",
                     $time, rsp_count, what, got, want);
    endtask

    task automatic build_stimulus();
        int                  produced;
        int                  kind;
        int                  len;
        int                  r;
        bit                  quiet;
        bit                  pause_first;
        logic [REQ_BITS-1:0] op;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = KEY_W'($urandom());
        for (int i = 0; i < VALUE_POOL; i++)
            value_pool[i] = VAL_W'($urandom());
        key_pool[0]   = '0;
        key_pool[1]   = '1;
        key_pool[2]   = 32'h8000_0000;
        key_pool[3]   = 32'h7FFF_FFFF;
        value_pool[0] = '0;
        value_pool[1] = '1;

        // Directed: misses on an empty table, inserts at both ends and in the middle,
        // early-stopping lookups, an update, removals, unused codes and clears.
        add_request(REQ_LOOKUP, 32'h0, 32'h0, 1'b0, 1'b0);
        add_request(REQ_REMOVE_KEY, 32'h0, 32'h0, 1'b0, 1'b0);
        add_request(REQ_REMOVE_VALUE, 32'h0, 32'h0, 1'b0, 1'b0);
        add_request(REQ_ENTER, 32'h8000_0000, 32'h1234_5678, 1'b0, 1'b0);
        add_request(REQ_ENTER, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_request(REQ_ENTER, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        add_request(REQ_ENTER, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0);
        add_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        add_request(REQ_LOOKUP, 32'h0, 32'h0, 1'b0, 1'b0);
        add_request(REQ_LOOKUP, 32'h4000_0000, 32'h0, 1'b0, 1'b0);
        add_request(REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0, 1'b0, 1'b0);
        add_request(REQ_ENTER, 32'h8000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0);
        add_request(REQ_REMOVE_VALUE, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_request(REQ_REMOVE_VALUE, 32'h0, 32'h1357_9BDF, 1'b0, 1'b0);
        add_request(REQ_REMOVE_KEY, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        add_request(REQ_REMOVE_KEY, 32'h1, 32'h0, 1'b0, 1'b0);
        for (int i = 0; i < 3; i++)
            add_request(REQ_UNUSED_FIRST + REQ_BITS'(i), '1, '1, 1'b0, 1'b0);
        add_request(REQ_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        add_request(REQ_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
        add_request(REQ_CLEAR, '1, '1, 1'b0, 1'b0);

        // Random part in sequences. The first one is a fill run that starts once every earlier response is in.
        produced    = 0;
        kind        = SEQ_FILL;
        pause_first = 1'b1;
        while (produced < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            len   = (kind == SEQ_FILL) ? $urandom_range(30, 70) : $urandom_range(10, 40);
            for (int n = 0; n < len; n++)
            begin
                r = $urandom_range(0, 99);
                if (kind == SEQ_FILL)
                    op = (n >= len - 3) ? REQ_LOOKUP : REQ_ENTER;
                else if (kind == SEQ_DRAIN)
                    op = (r < 45) ? REQ_REMOVE_KEY : (r < 80) ? REQ_REMOVE_VALUE : REQ_LOOKUP;
                else if (r < 25)
                    op = REQ_LOOKUP;
                else if (r < 55)
                    op = REQ_ENTER;
                else if (r < 70)
                    op = REQ_REMOVE_VALUE;
                else if (r < 90)
                    op = REQ_REMOVE_KEY;
                else if (r < 93)
                    op = REQ_CLEAR;
                else
                    op = REQ_UNUSED_FIRST + REQ_BITS'($urandom_range(0, 2));
                add_request(op, pick_key(), pick_value(), pause_first && n == 0, quiet);
                if (op <= REQ_CLEAR)
                    produced++;
            end
            r           = $urandom_range(0, 9);
            kind        = (r < 3) ? SEQ_FILL : (r < 8) ? SEQ_MIXED : SEQ_DRAIN;
            pause_first = ($urandom_range(0, 9) == 0);
        end
        total_requests = queued_requests.size();
    endtask

    // Request driver: holds an offered transaction until it is taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.key      <= '0;
            req_ch.value    <= '0;
            send_gap = 0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (queued_requests.size() == 0 ||
                     (queued_requests[0].drain_first && awaited_answers.size() != 0))
                req_ch.valid <= 1'b0;
            else
            begin
                next_req = queued_requests.pop_front();
                req_ch.req_type <= next_req.op;
                req_ch.key      <= next_req.key;
                req_ch.value    <= next_req.value;
                req_ch.valid    <= 1'b1;
                send_gap = next_req.burst ? 0 : pick_gap();
            end
        end
    end

    // Response receiver: random stalls, calm stretches, and long hold-offs that back
    // the block up while the driver keeps offering.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_count >= next_hold_at)
        begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 700;
            rsp_ch.ready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(30, 120);
            else
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_count++;
                if (awaited_answers.size() == 0)
                    report_mismatch("unexpected response, entry_count",
                                    32'(rsp_ch.entry_count), 32'h0);
                else
                begin
                    next_answer = awaited_answers.pop_front();
                    if (rsp_ch.found !== next_answer.found)
                        report_mismatch("found", 32'(rsp_ch.found), 32'(next_answer.found));
                    if (rsp_ch.value_out !== next_answer.value_out)
                        report_mismatch("value_out", 32'(rsp_ch.value_out),
                                        32'(next_answer.value_out));
                    if (rsp_ch.status !== next_answer.status)
                        report_mismatch("status", 32'(rsp_ch.status),
                                        32'(next_answer.status));
                    if (rsp_ch.entry_count !== next_answer.entry_count)
                        report_mismatch("entry_count", 32'(rsp_ch.entry_count),
                                        32'(next_answer.entry_count));
                    if (next_answer.status == STATUS_FULL)
                        full_seen++;
                    if (next_answer.found)
                        hit_seen++;
                    if (int'(next_answer.entry_count) > max_fill_seen)
                        max_fill_seen = int'(next_answer.entry_count);
                end
            end
            if (req_taken)
            begin
                seen_req.op    = req_ch.req_type;
                seen_req.key   = req_ch.key;
                seen_req.value = req_ch.value;
                op_seen[seen_req.op]++;
                accepted_reqs++;
                awaited_answers.push_back(apply_map_request(seen_req));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("Timeout: no transaction for %0d cycles, %0d responses pending",
                             idle_cycles, awaited_answers.size());
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.key      = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        for (int i = 0; i < 8; i++)
            op_seen[i] = 0;
        build_stimulus();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_reqs < total_requests || awaited_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d requests: %0d lookups, %0d enters, %0d removes by value, %0d removes by key, %0d clears, %0d unused codes.",
                 accepted_reqs, op_seen[REQ_LOOKUP], op_seen[REQ_ENTER],
                 op_seen[REQ_REMOVE_VALUE], op_seen[REQ_REMOVE_KEY], op_seen[REQ_CLEAR],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("Hits and removals: %0d, inserts refused on a full table: %0d, peak entry count: %0d.",
                 hit_seen, full_seen, max_fill_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
